// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also watches the reset cycles themselves.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/bcg_pkg.sv =====
// Types, constants and functions shared by the gray convert block.
`default_nettype none

package bcg_pkg;

    localparam int MAX_PIXELS_LOG2 = 22;
    localparam int CNT_W  = MAX_PIXELS_LOG2 + 1;
    localparam int SUM_W  = MAX_PIXELS_LOG2 + 8;
    localparam int PROD_W = CNT_W + 8;

    localparam int WSUM_W = 22;
    localparam logic [WSUM_W-1:0] W_BLUE  = 22'd1868;
    localparam logic [WSUM_W-1:0] W_GREEN = 22'd9617;
    localparam logic [WSUM_W-1:0] W_RED   = 22'd4899;
    localparam logic [WSUM_W-1:0] W_ROUND = 22'd8192;
    localparam int GRAY_SHIFT = 14;

    localparam logic [7:0] WHITE = 8'd255;

    typedef enum logic [2:0] {
        CFG_COLOR_INPUT = 3'd0,
        CFG_DARK_LIMIT  = 3'd1,
        CFG_LIGHT_LIMIT = 3'd2,
        CFG_MIN_MEAN    = 3'd3,
        CFG_MAX_MEAN    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic       color_input;
        logic [7:0] dark_limit;
        logic [7:0] light_limit;
        logic [7:0] min_mean;
        logic [7:0] max_mean;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        color_input: 1'b1,
        dark_limit:  8'd160,
        light_limit: 8'd180,
        min_mean:    8'd7,
        max_mean:    8'd251
    };

    // One converted pixel travelling from the gray stage to the statistics stage.
    typedef struct packed {
        logic [7:0] gray;
        logic       last;
    } t_pix;

    // Fixed-point luma with the weights summing to 2^14.
    function automatic logic [7:0] to_gray(input logic [7:0] b, input logic [7:0] g,
                                           input logic [7:0] r);
        logic [WSUM_W-1:0] acc;
        acc = W_BLUE * WSUM_W'(b) + W_GREEN * WSUM_W'(g) + W_RED * WSUM_W'(r) + W_ROUND;
        return acc[GRAY_SHIFT +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bcg_gray.sv =====
// Input register, pixel cleaning and gray conversion, and the gray register.
`default_nettype none

module bcg_gray (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bcg_pkg::t_cfg i_cfg,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_blue,
    input  wire logic [7:0]    i_green,
    input  wire logic [7:0]    i_red,
    input  wire logic          i_last_pixel,
    output logic               o_pix_valid,
    input  wire logic          i_pix_ready,
    output bcg_pkg::t_pix      o_pix
);
    import bcg_pkg::*;

    logic       r_s1_valid;
    logic [7:0] r_blue;
    logic [7:0] r_green;
    logic [7:0] r_red;
    logic       r_last;
    logic       r_s2_valid;
    t_pix       r_pix;
    t_pix       n_pix;
    logic       s1_ready;
    logic       s2_ready;
    logic       is_dark;
    logic       is_light;

    assign s2_ready = !r_s2_valid || i_pix_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_stall  = !s1_ready;

    always_comb begin
        is_dark  = (r_blue < i_cfg.dark_limit) && (r_green < i_cfg.dark_limit) &&
                   (r_red < i_cfg.dark_limit);
        is_light = (r_blue > i_cfg.light_limit) && (r_green > i_cfg.light_limit) &&
                   (r_red > i_cfg.light_limit);
        n_pix.last = r_last;
        if (!i_cfg.color_input) begin
            n_pix.gray = r_blue;
        end else if (is_dark || is_light) begin
            n_pix.gray = to_gray(r_blue, r_green, r_red);
        end else begin
            // A whitened pixel converts to full white since the weights sum to 2^14.
            n_pix.gray = to_gray(WHITE, WHITE, WHITE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && s1_ready) begin
            r_blue  <= i_blue;
            r_green <= i_green;
            r_red   <= i_red;
            r_last  <= i_last_pixel;
        end
        if (r_s1_valid && s2_ready) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix_valid = r_s2_valid;
    assign o_pix       = r_pix;

endmodule

`default_nettype wire

// ===== hdl/bcg_stats.sv =====
// Brightness accumulator, mean limit products and compare, and the result register.
`default_nettype none

module bcg_stats (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bcg_pkg::t_cfg i_cfg,
    input  wire logic          i_pix_valid,
    output logic               o_pix_ready,
    input  wire bcg_pkg::t_pix i_pix,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [7:0]         o_gray,
    output logic               o_last_out,
    output logic               o_image_ok
);
    import bcg_pkg::*;

    logic              r_sum_valid;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_count;
    logic [SUM_W-1:0]  n_sum;
    logic [CNT_W-1:0]  n_count;

    logic              r_s3_valid;
    t_pix              r_s3_pix;
    logic [SUM_W-1:0]  r_s3_sum;
    logic [CNT_W-1:0]  r_s3_count;

    logic              r_s4_valid;
    t_pix              r_s4_pix;
    logic [SUM_W-1:0]  r_s4_sum;
    logic [PROD_W-1:0] r_s4_min;
    logic [PROD_W-1:0] r_s4_max;

    logic              r_out_valid;
    t_pix              r_out_pix;
    logic              r_out_ok;
    logic              n_ok;

    logic              out_ready;
    logic              s4_ready;
    logic              s3_ready;

    assign out_ready   = !r_out_valid || !i_stall;
    assign s4_ready    = !r_s4_valid || out_ready;
    assign s3_ready    = !r_s3_valid || s4_ready;
    assign o_pix_ready = s3_ready;

    // The count saturates at its limit; the top count bit set means the limit is reached.
    always_comb begin
        if (!r_count[MAX_PIXELS_LOG2]) begin
            n_sum   = r_sum + SUM_W'(i_pix.gray);
            n_count = r_count + CNT_W'(1);
        end else begin
            n_sum   = r_sum;
            n_count = r_count;
        end
    end

    assign n_ok = r_s4_pix.last && (PROD_W'(r_s4_sum) > r_s4_min) &&
                  (PROD_W'(r_s4_sum) < r_s4_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
            r_sum       <= '0;
            r_count     <= '0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum_valid <= 1'b1;
            if (i_pix_valid && s3_ready) begin
                if (i_pix.last) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= n_sum;
                    r_count <= n_count;
                end
            end
            if (s3_ready) begin
                r_s3_valid <= i_pix_valid;
            end
            if (s4_ready) begin
                r_s4_valid <= r_s3_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix_valid && s3_ready) begin
            r_s3_pix   <= i_pix;
            r_s3_sum   <= n_sum;
            r_s3_count <= n_count;
        end
        if (r_s3_valid && s4_ready) begin
            r_s4_pix <= r_s3_pix;
            r_s4_sum <= r_s3_sum;
            r_s4_min <= PROD_W'(i_cfg.min_mean) * PROD_W'(r_s3_count);
            r_s4_max <= PROD_W'(i_cfg.max_mean) * PROD_W'(r_s3_count);
        end
        if (r_s4_valid && out_ready) begin
            r_out_pix <= r_s4_pix;
            r_out_ok  <= n_ok && r_sum_valid;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_gray     = r_out_pix.gray;
    assign o_last_out = r_out_pix.last;
    assign o_image_ok = r_out_ok;

endmodule

`default_nettype wire

// ===== hdl/bilevel_clean_gray_convert_unit.sv =====
// Top level of the bilevel clean and gray convert block: configuration and two stages.
// A pixel accepted at the input passes the input, gray, sum, limit product and result
// registers in that order. Throughput: one pixel per clock while the result is not
// stalled. The five pipeline registers each move on when the register after them is
// free or being emptied; a stalled result holds up the input only once all five are full.
// Reset: synchronous, active low; clears the pipeline, the image sum and count, and
// restores all configuration registers to their documented defaults.
`default_nettype none

module bilevel_clean_gray_convert_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration write channel; indexes beyond the register list are ignored.
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    // Pixel input channel.
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_blue,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_red,
    input  wire logic       i_last_pixel,
    // Result channel.
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_gray,
    output logic            o_last_out,
    output logic            o_image_ok
);
    import bcg_pkg::*;

    t_cfg r_cfg;
    t_pix pix;
    logic pix_valid;
    logic pix_ready;

    // The register file accepts a write in every cycle. The user writes it only while
    // the pipeline is empty, so the stages can read it directly without shadow copies.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COLOR_INPUT: r_cfg.color_input <= i_cfg_data[0];
                CFG_DARK_LIMIT:  r_cfg.dark_limit  <= i_cfg_data;
                CFG_LIGHT_LIMIT: r_cfg.light_limit <= i_cfg_data;
                CFG_MIN_MEAN:    r_cfg.min_mean    <= i_cfg_data;
                CFG_MAX_MEAN:    r_cfg.max_mean    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // First half: the pixel is registered; with color input it is cleaned toward white unless
    // clearly dark or light and converted to gray, else blue is taken as gray; then registered.
    bcg_gray u_gray (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_blue       (i_blue),
        .i_green      (i_green),
        .i_red        (i_red),
        .i_last_pixel (i_last_pixel),
        .o_pix_valid  (pix_valid),
        .i_pix_ready  (pix_ready),
        .o_pix        (pix)
    );

    // Second half: the gray value is added into the image sum, the mean limits are
    // scaled by the pixel count in a registered multiply, and the last pixel of an
    // image carries the verdict of the two compares.
    bcg_stats u_stats (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pix_valid (pix_valid),
        .o_pix_ready (pix_ready),
        .i_pix       (pix),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_gray      (o_gray),
        .o_last_out  (o_last_out),
        .o_image_ok  (o_image_ok)
    );

endmodule

`default_nettype wire

// ===== hdl/bcg_checker.sv =====
// Port-level checks for the gray convert block and the bind that attaches them.
`default_nettype none
`include "assert_macros.svh"

module bcg_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       o_stall,
    input  wire logic       o_valid,
    input  wire logic       i_stall,
    input  wire logic [7:0] o_gray,
    input  wire logic       o_last_out,
    input  wire logic       o_image_ok
);

    // A result held back by the receiver keeps its valid and its fields.
    `ASSERT_CLK(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_gray) && $stable(o_last_out) && $stable(o_image_ok), "result changed while stalled")

    // The image verdict is only ever raised on the final pixel of an image.
    `ASSERT_CLK(a_ok_only_last, o_valid && !o_last_out |-> !o_image_ok, "image_ok set on a pixel that is not last")

    // Reset empties the pipeline: no result is offered right after it.
    `ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "result valid after reset")

    // With an empty pipeline the input side cannot be stalled.
    `ASSERT_ALWAYS(a_reset_ready, !i_rst_n |=> !o_stall, "input stalled after reset")

endmodule

bind bilevel_clean_gray_convert_unit bcg_checker u_bcg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_gray     (o_gray),
    .o_last_out (o_last_out),
    .o_image_ok (o_image_ok)
);

`default_nettype wire
